[design/lppb_pkg.sv]
package lppb_pkg;

  // Operation codes of an input beat.
  localparam logic [2:0] OP_CLEAR  = 3'd0;
  localparam logic [2:0] OP_PARAM  = 3'd1;
  localparam logic [2:0] OP_LOAD   = 3'd2;
  localparam logic [2:0] OP_POINT  = 3'd3;
  localparam logic [2:0] OP_COMMIT = 3'd4;
  localparam logic [2:0] OP_QUERY  = 3'd5;

  // Result status codes.
  localparam logic [2:0] ST_ACK    = 3'd0;
  localparam logic [2:0] ST_IGN    = 3'd1;
  localparam logic [2:0] ST_DONE   = 3'd2;
  localparam logic [2:0] ST_BEHIND = 3'd3;
  localparam logic [2:0] ST_OUT    = 3'd4;
  localparam logic [2:0] ST_NOBOX  = 3'd5;
  localparam logic [2:0] ST_MATCH  = 3'd6;
  localparam logic [2:0] ST_BADCAM = 3'd7;

  // Camera parameter selectors that the datapath uses by name.
  localparam logic [3:0] SEL_FX     = 4'd9;
  localparam logic [3:0] SEL_FY     = 4'd10;
  localparam logic [3:0] SEL_CX     = 4'd11;
  localparam logic [3:0] SEL_CY     = 4'd12;
  localparam logic [3:0] SEL_WIDTH  = 4'd13;
  localparam logic [3:0] SEL_HEIGHT = 4'd14;
  localparam logic [3:0] SEL_BAD    = 4'd15;

  // Datapath commands issued by the controller.
  localparam logic [3:0] CMD_NONE  = 4'd0;
  localparam logic [3:0] CMD_CAP   = 4'd1;
  localparam logic [3:0] CMD_DEC   = 4'd2;
  localparam logic [3:0] CMD_CLR   = 4'd3;
  localparam logic [3:0] CMD_MARK  = 4'd4;
  localparam logic [3:0] CMD_XFORM = 4'd5;
  localparam logic [3:0] CMD_ZCHK  = 4'd6;
  localparam logic [3:0] CMD_DIV   = 4'd7;
  localparam logic [3:0] CMD_PROJ  = 4'd8;
  localparam logic [3:0] CMD_BOUND = 4'd9;
  localparam logic [3:0] CMD_SRCH  = 4'd10;
  localparam logic [3:0] CMD_MATCH = 4'd11;
  localparam logic [3:0] CMD_QRY   = 4'd12;
  localparam logic [3:0] CMD_RESP  = 4'd13;

  // Outcome of decoding a captured beat.
  localparam logic [1:0] KIND_DONE  = 2'd0;
  localparam logic [1:0] KIND_CLEAR = 2'd1;
  localparam logic [1:0] KIND_QUERY = 2'd2;
  localparam logic [1:0] KIND_POINT = 2'd3;

  typedef struct packed {
    logic        [2:0]  op;
    logic        [3:0]  param_sel;
    logic signed [31:0] param_value;
    logic        [5:0]  box_slot;
    logic        [13:0] box_left;
    logic        [13:0] box_top;
    logic        [13:0] box_right;
    logic        [13:0] box_bottom;
    logic        [11:0] point_index;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
  } lppb_in_t;

  typedef struct packed {
    logic        [2:0]  status;
    logic signed [31:0] u_pixel;
    logic signed [31:0] v_pixel;
    logic        [5:0]  global_box;
    logic        [11:0] rank_in_box;
    logic        [12:0] box_total;
    logic        [12:0] box_offset;
    logic        [31:0] behind_total;
    logic        [31:0] outside_total;
  } lppb_out_t;

  typedef struct packed {
    logic [13:0] left;
    logic [13:0] top;
    logic [13:0] right;
    logic [13:0] bottom;
  } lppb_box_t;

  typedef struct packed {
    logic [3:0] code;
    logic [5:0] step;
  } lppb_cmd_t;

  typedef struct packed {
    logic [1:0] kind;
    logic       mark_hit;
    logic       z_pos;
    logic       outside;
    logic       srch_hit;
    logic       srch_miss;
    logic       qry_done;
    logic       clr_last;
    logic       out_free;
  } lppb_stat_t;

  // Saturate a wide signed value to 32 bits.
  function automatic logic signed [31:0] sat32(input logic signed [49:0] v);
    if (v > 50'sd2147483647) begin
      return 32'sh7fffffff;
    end else if (v < -50'sd2147483648) begin
      return 32'sh80000000;
    end else begin
      return v[31:0];
    end
  endfunction

endpackage

[design/lidar_point_projection_box_binning.sv]
// Point beat: the mark check, the transform, the 33-step divider, the projection,
// the bounds test and the box store walk of one box a cycle. Query: a walk over the
// count store from box zero up to the queried box. Clear: a sweep of the point marks.
// One beat is processed at a time; the output register lets the next beat in.
// Reset (synchronous, active low) clears all control state and then sweeps the
// point marks, during which no beat is accepted.
module lidar_point_projection_box_binning #(
  parameter int MAX_POINTS = 4096,
  parameter int MAX_BOXES  = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  lppb_pkg::lppb_in_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output lppb_pkg::lppb_out_t out_data
);

  lppb_pkg::lppb_cmd_t  cmd;
  lppb_pkg::lppb_stat_t stat;

  // Sequencer.
  lppb_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Arithmetic, stores and result register.
  lppb_dp #(.MAX_POINTS(MAX_POINTS), .MAX_BOXES(MAX_BOXES)) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .out_stall (out_stall),
    .stat      (stat),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  // An accepted beat is always captured by the datapath.
  a_accept_cap: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |-> cmd.code == lppb_pkg::CMD_CAP)
    else $error("accepted beat not captured");

  // A new result appears only after a response command.
  a_out_from_resp: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(cmd.code == lppb_pkg::CMD_RESP))
    else $error("result without response command");

  // A count update follows a search hit directly.
  a_match_after_hit: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.code == lppb_pkg::CMD_MATCH |-> $past(stat.srch_hit))
    else $error("match without search hit");

endmodule

[design/lppb_ram.sv]
module lppb_ram #(
  parameter int W = 8,
  parameter int D = 16
) (
  input  logic                           clk,
  input  logic                           we,
  input  logic [((D > 1) ? $clog2(D) : 1)-1:0] waddr,
  input  logic [W-1:0]                   wdata,
  input  logic [((D > 1) ? $clog2(D) : 1)-1:0] raddr,
  output logic [W-1:0]                   rdata
);

  logic [W-1:0] mem [D];

  // One write port, one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[design/lppb_ctrl.sv]
module lppb_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  lppb_pkg::lppb_stat_t  stat,
  output lppb_pkg::lppb_cmd_t   cmd
);

  localparam logic [3:0] S_INIT  = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_DEC   = 4'd2;
  localparam logic [3:0] S_CLEAR = 4'd3;
  localparam logic [3:0] S_MARK  = 4'd4;
  localparam logic [3:0] S_XFORM = 4'd5;
  localparam logic [3:0] S_ZCHK  = 4'd6;
  localparam logic [3:0] S_DIV   = 4'd7;
  localparam logic [3:0] S_PROJ  = 4'd8;
  localparam logic [3:0] S_BOUND = 4'd9;
  localparam logic [3:0] S_SRCH  = 4'd10;
  localparam logic [3:0] S_MATCH = 4'd11;
  localparam logic [3:0] S_QUERY = 4'd12;
  localparam logic [3:0] S_RESP  = 4'd13;

  localparam logic [5:0] XFORM_LAST = 6'd6;
  localparam logic [5:0] DIV_LAST   = 6'd32;
  localparam logic [5:0] PROJ_LAST  = 6'd4;

  logic [3:0] state_r, state_nxt;
  logic [5:0] cnt_r, cnt_nxt;

  assign in_stall = (state_r != S_IDLE);

  // Command for the datapath in the current state.
  always_comb begin
    cmd.step = cnt_r;
    unique case (state_r)
      S_INIT, S_CLEAR: cmd.code = lppb_pkg::CMD_CLR;
      S_IDLE:  cmd.code = in_valid ? lppb_pkg::CMD_CAP : lppb_pkg::CMD_NONE;
      S_DEC:   cmd.code = lppb_pkg::CMD_DEC;
      S_MARK:  cmd.code = lppb_pkg::CMD_MARK;
      S_XFORM: cmd.code = lppb_pkg::CMD_XFORM;
      S_ZCHK:  cmd.code = lppb_pkg::CMD_ZCHK;
      S_DIV:   cmd.code = lppb_pkg::CMD_DIV;
      S_PROJ:  cmd.code = lppb_pkg::CMD_PROJ;
      S_BOUND: cmd.code = lppb_pkg::CMD_BOUND;
      S_SRCH:  cmd.code = lppb_pkg::CMD_SRCH;
      S_MATCH: cmd.code = lppb_pkg::CMD_MATCH;
      S_QUERY: cmd.code = lppb_pkg::CMD_QRY;
      S_RESP:  cmd.code = lppb_pkg::CMD_RESP;
      default: cmd.code = lppb_pkg::CMD_NONE;
    endcase
  end

  // Next state and step counter.
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r + 6'd1;
    unique case (state_r)
      S_INIT:  if (stat.clr_last) state_nxt = S_IDLE;
      S_IDLE:  if (in_valid) state_nxt = S_DEC;
      S_DEC: begin
        unique case (stat.kind)
          lppb_pkg::KIND_CLEAR: state_nxt = S_CLEAR;
          lppb_pkg::KIND_QUERY: state_nxt = S_QUERY;
          lppb_pkg::KIND_POINT: state_nxt = S_MARK;
          default:              state_nxt = S_RESP;
        endcase
      end
      S_CLEAR: if (stat.clr_last) state_nxt = S_RESP;
      S_MARK: begin
        cnt_nxt   = '0;
        state_nxt = stat.mark_hit ? S_RESP : S_XFORM;
      end
      S_XFORM: if (cnt_r == XFORM_LAST) state_nxt = S_ZCHK;
      S_ZCHK: begin
        cnt_nxt   = '0;
        state_nxt = stat.z_pos ? S_DIV : S_RESP;
      end
      S_DIV: begin
        if (cnt_r == DIV_LAST) begin
          cnt_nxt   = '0;
          state_nxt = S_PROJ;
        end
      end
      S_PROJ:  if (cnt_r == PROJ_LAST) state_nxt = S_BOUND;
      S_BOUND: state_nxt = stat.outside ? S_RESP : S_SRCH;
      S_SRCH: begin
        if (stat.srch_hit) begin
          state_nxt = S_MATCH;
        end else if (stat.srch_miss) begin
          state_nxt = S_RESP;
        end
      end
      S_MATCH: state_nxt = S_RESP;
      S_QUERY: if (stat.qry_done) state_nxt = S_RESP;
      S_RESP:  if (stat.out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // After reset the controller runs the mark clearing sweep first.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

[design/lppb_dp.sv]
module lppb_dp #(
  parameter int MAX_POINTS = 4096,
  parameter int MAX_BOXES  = 64
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  lppb_pkg::lppb_in_t   in_data,
  input  lppb_pkg::lppb_cmd_t  cmd,
  input  logic                 out_stall,
  output lppb_pkg::lppb_stat_t stat,
  output logic                 out_valid,
  output lppb_pkg::lppb_out_t  out_data
);

  localparam int MAW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CAW = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
  localparam int BW  = $clog2(MAX_BOXES + 1);
  localparam logic [8:0]  MaxBoxes9  = 9'(MAX_BOXES);
  localparam logic [16:0] MaxPoints17 = 17'(MAX_POINTS);
  localparam logic [MAW-1:0] LastPoint = MAW'(MAX_POINTS - 1);

  // Captured beat, camera registers and bookkeeping.
  lppb_pkg::lppb_in_t  item_r;
  lppb_pkg::lppb_out_t res_r, out_r;
  logic                out_valid_r;
  logic [31:0]         cam_r [15];
  logic [BW-1:0]       base_r;
  logic [6:0]          loaded_r;
  logic [31:0]         behind_r, outside_r;
  logic [MAX_BOXES-1:0] cnt_vld_r;
  logic [MAW-1:0]      clr_addr_r;

  // Arithmetic registers.
  logic signed [67:0]  prod_r;
  logic signed [49:0]  acc_r;
  logic signed [31:0]  camx_r, camy_r, camz_r, tu_r, tv_r;
  logic [32:0]         rem_r, inv_r;
  logic signed [49:0]  u_r, v_r;

  // Search and query sequencing.
  logic [6:0]          sidx_r;
  logic                sv_r;
  logic [5:0]          sk_r;
  logic [CAW-1:0]      gb_r, qidx_r, qk_r;
  logic                qv_r, cv_rd_r;
  logic [12:0]         off_r;

  // Combinational signals.
  logic [8:0]          room9, nb9, sum9, gb9;
  logic                badcam, idx_ok, slot_ok, qry_ok, sel_ok;
  logic [1:0]          kind;
  logic signed [49:0]  sh;
  logic signed [33:0]  mul_a, mul_b;
  logic [MAW-1:0]      idx_addr, mark_waddr;
  logic                mark_we, mark_rdata;
  logic                box_we;
  lppb_pkg::lppb_box_t box_wdata, box_rdata;
  logic                inbox, hit, miss, zpos, outside, qdone;
  logic [31:0]         ui, vi;
  logic signed [49:0]  w_lim, h_lim;
  logic [CAW-1:0]      cnt_raddr, q_gb;
  logic [12:0]         cnt_rdata, cnt_val;
  logic                out_free;
  logic [32:0]         rem_sh, zdiv;
  logic                div_ge;

  // Room left for boxes in this call and the number usable for search.
  assign room9  = MaxBoxes9 - 9'(base_r);
  assign nb9    = (9'(loaded_r) < room9) ? 9'(loaded_r) : room9;
  assign sum9   = 9'(base_r) + 9'(loaded_r);
  assign badcam = (cam_r[lppb_pkg::SEL_WIDTH] == '0) || (cam_r[lppb_pkg::SEL_HEIGHT] == '0) ||
                  (cam_r[lppb_pkg::SEL_FX] == '0) || (cam_r[lppb_pkg::SEL_FY] == '0);
  assign idx_ok  = 17'(item_r.point_index) < MaxPoints17;
  assign slot_ok = 9'(item_r.box_slot) < room9;
  assign qry_ok  = 9'(item_r.box_slot) < MaxBoxes9;
  assign sel_ok  = item_r.param_sel != lppb_pkg::SEL_BAD;
  assign idx_addr = MAW'(item_r.point_index);
  assign q_gb     = CAW'(item_r.box_slot);

  // Decode outcome of the captured beat.
  always_comb begin
    unique case (item_r.op)
      lppb_pkg::OP_CLEAR: kind = lppb_pkg::KIND_CLEAR;
      lppb_pkg::OP_POINT: kind = (badcam || !idx_ok || nb9 == '0) ?
                                 lppb_pkg::KIND_DONE : lppb_pkg::KIND_POINT;
      lppb_pkg::OP_QUERY: kind = qry_ok ? lppb_pkg::KIND_QUERY : lppb_pkg::KIND_DONE;
      default:            kind = lppb_pkg::KIND_DONE;
    endcase
  end

  // Shared multiplier operand selection.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (cmd.code == lppb_pkg::CMD_XFORM) begin
      unique case (cmd.step)
        6'd0: begin mul_a = 34'($signed(cam_r[0])); mul_b = 34'(item_r.point_x); end
        6'd1: begin mul_a = 34'($signed(cam_r[1])); mul_b = 34'(item_r.point_y); end
        6'd2: begin mul_a = 34'($signed(cam_r[3])); mul_b = 34'(item_r.point_x); end
        6'd3: begin mul_a = 34'($signed(cam_r[4])); mul_b = 34'(item_r.point_y); end
        6'd4: begin mul_a = 34'($signed(cam_r[6])); mul_b = 34'(item_r.point_x); end
        6'd5: begin mul_a = 34'($signed(cam_r[7])); mul_b = 34'(item_r.point_y); end
        default: ;
      endcase
    end else if (cmd.code == lppb_pkg::CMD_PROJ) begin
      unique case (cmd.step)
        6'd0: begin mul_a = 34'($signed(cam_r[lppb_pkg::SEL_FX])); mul_b = 34'(camx_r); end
        6'd1: begin mul_a = 34'($signed(cam_r[lppb_pkg::SEL_FY])); mul_b = 34'(camy_r); end
        6'd2: begin mul_a = 34'(tu_r); mul_b = $signed({1'b0, inv_r}); end
        6'd3: begin mul_a = 34'(tv_r); mul_b = $signed({1'b0, inv_r}); end
        default: ;
      endcase
    end
  end

  // Floored product in Q16.16.
  assign sh = prod_r[65:16];

  // One restoring division step of 2^32 by z.
  assign rem_sh = {rem_r[31:0], (cmd.step == '0)};
  assign zdiv   = {1'b0, camz_r};
  assign div_ge = rem_sh >= zdiv;

  // Image bounds on the unsaturated projection.
  assign zpos    = camz_r > 32'sd0;
  assign w_lim   = $signed({2'b00, cam_r[lppb_pkg::SEL_WIDTH], 16'h0000});
  assign h_lim   = $signed({2'b00, cam_r[lppb_pkg::SEL_HEIGHT], 16'h0000});
  assign outside = (u_r < 50'sd0) || (v_r < 50'sd0) || (u_r >= w_lim) || (v_r >= h_lim);
  assign ui      = u_r[47:16];
  assign vi      = v_r[47:16];

  // Box search compare on the registered box read.
  assign inbox = (ui >= 32'(box_rdata.left)) && (ui < 32'(box_rdata.right)) &&
                 (vi >= 32'(box_rdata.top)) && (vi < 32'(box_rdata.bottom));
  assign hit   = (cmd.code == lppb_pkg::CMD_SRCH) && sv_r && inbox;
  assign miss  = (cmd.code == lppb_pkg::CMD_SRCH) && sv_r && !inbox &&
                 (9'(sk_r) == nb9 - 9'd1);
  assign gb9   = 9'(base_r) + 9'(sk_r);

  // Count store read: the query walk or the matched box.
  assign cnt_raddr = (cmd.code == lppb_pkg::CMD_QRY) ? qidx_r : gb9[CAW-1:0];
  assign cnt_val   = cv_rd_r ? cnt_rdata : 13'd0;
  assign qdone     = qv_r && (qk_r == q_gb);

  // Memory write controls.
  assign mark_we    = (cmd.code == lppb_pkg::CMD_CLR) || (cmd.code == lppb_pkg::CMD_MATCH);
  assign mark_waddr = (cmd.code == lppb_pkg::CMD_CLR) ? clr_addr_r : idx_addr;
  assign box_we     = (cmd.code == lppb_pkg::CMD_DEC) && (item_r.op == lppb_pkg::OP_LOAD) &&
                      slot_ok;
  assign box_wdata  = '{left: item_r.box_left, top: item_r.box_top,
                        right: item_r.box_right, bottom: item_r.box_bottom};

  lppb_ram #(.W(1), .D(MAX_POINTS)) u_mark_ram (
    .clk   (clk),
    .we    (mark_we),
    .waddr (mark_waddr),
    .wdata (cmd.code == lppb_pkg::CMD_MATCH),
    .raddr (idx_addr),
    .rdata (mark_rdata)
  );

  lppb_ram #(.W($bits(lppb_pkg::lppb_box_t)), .D(64)) u_box_ram (
    .clk   (clk),
    .we    (box_we),
    .waddr (item_r.box_slot),
    .wdata (box_wdata),
    .raddr (sidx_r[5:0]),
    .rdata (box_rdata)
  );

  lppb_ram #(.W(13), .D(MAX_BOXES)) u_cnt_ram (
    .clk   (clk),
    .we    (cmd.code == lppb_pkg::CMD_MATCH),
    .waddr (gb_r),
    .wdata (cnt_val + 13'd1),
    .raddr (cnt_raddr),
    .rdata (cnt_rdata)
  );

  assign out_free = !out_valid_r || !out_stall;

  // Status back to the controller.
  assign stat = '{kind: kind, mark_hit: mark_rdata, z_pos: zpos, outside: outside,
                  srch_hit: hit, srch_miss: miss, qry_done: qdone,
                  clr_last: (clr_addr_r == LastPoint), out_free: out_free};

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Control state with reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 15; i++) cam_r[i] <= '0;
      base_r      <= '0;
      loaded_r    <= '0;
      behind_r    <= '0;
      outside_r   <= '0;
      cnt_vld_r   <= '0;
      clr_addr_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_free) begin
        out_valid_r <= (cmd.code == lppb_pkg::CMD_RESP);
      end
      unique case (cmd.code)
        lppb_pkg::CMD_DEC: begin
          unique case (item_r.op)
            lppb_pkg::OP_CLEAR: begin
              base_r     <= '0;
              loaded_r   <= '0;
              behind_r   <= '0;
              outside_r  <= '0;
              cnt_vld_r  <= '0;
              clr_addr_r <= '0;
            end
            lppb_pkg::OP_PARAM: if (sel_ok) cam_r[item_r.param_sel] <= item_r.param_value;
            lppb_pkg::OP_LOAD: begin
              if (slot_ok && (7'(item_r.box_slot) + 7'd1 > loaded_r)) begin
                loaded_r <= 7'(item_r.box_slot) + 7'd1;
              end
            end
            lppb_pkg::OP_COMMIT: begin
              base_r   <= (sum9 > MaxBoxes9) ? BW'(MAX_BOXES) : sum9[BW-1:0];
              loaded_r <= '0;
            end
            default: ;
          endcase
        end
        lppb_pkg::CMD_CLR:   clr_addr_r <= (clr_addr_r == LastPoint) ? '0 : clr_addr_r + 1'b1;
        lppb_pkg::CMD_ZCHK:  if (!zpos) behind_r <= behind_r + 32'd1;
        lppb_pkg::CMD_BOUND: if (outside) outside_r <= outside_r + 32'd1;
        lppb_pkg::CMD_MATCH: cnt_vld_r[gb_r] <= 1'b1;
        default: ;
      endcase
    end
  end

  // Payload and arithmetic registers.
  always_ff @(posedge clk) begin
    prod_r  <= mul_a * mul_b;
    cv_rd_r <= cnt_vld_r[cnt_raddr];
    if ((cmd.code == lppb_pkg::CMD_RESP) && out_free) begin
      out_r               <= res_r;
      out_r.behind_total  <= behind_r;
      out_r.outside_total <= outside_r;
    end
    unique case (cmd.code)
      lppb_pkg::CMD_CAP: begin
        item_r <= in_data;
        res_r  <= '0;
      end
      lppb_pkg::CMD_DEC: begin
        qidx_r <= '0;
        qv_r   <= 1'b0;
        off_r  <= '0;
        unique case (item_r.op)
          lppb_pkg::OP_CLEAR, lppb_pkg::OP_COMMIT: ;
          lppb_pkg::OP_PARAM: if (!sel_ok) res_r.status <= lppb_pkg::ST_IGN;
          lppb_pkg::OP_LOAD:  if (!slot_ok) res_r.status <= lppb_pkg::ST_IGN;
          lppb_pkg::OP_POINT: begin
            if (badcam) begin
              res_r.status <= lppb_pkg::ST_BADCAM;
            end else if (!idx_ok || nb9 == '0) begin
              res_r.status <= lppb_pkg::ST_IGN;
            end
          end
          lppb_pkg::OP_QUERY: if (!qry_ok) res_r.status <= lppb_pkg::ST_IGN;
          default: res_r.status <= lppb_pkg::ST_IGN;
        endcase
      end
      lppb_pkg::CMD_MARK: if (mark_rdata) res_r.status <= lppb_pkg::ST_DONE;
      lppb_pkg::CMD_XFORM: begin
        // Rows of the transform: two products and an offset each.
        case (cmd.step)
          6'd1: acc_r  <= 50'($signed(cam_r[2])) + sh;
          6'd2: camx_r <= lppb_pkg::sat32(acc_r + sh);
          6'd3: acc_r  <= 50'($signed(cam_r[5])) + sh;
          6'd4: camy_r <= lppb_pkg::sat32(acc_r + sh);
          6'd5: acc_r  <= 50'($signed(cam_r[8])) + sh;
          6'd6: camz_r <= lppb_pkg::sat32(acc_r + sh);
          default: ;
        endcase
      end
      lppb_pkg::CMD_ZCHK: begin
        rem_r <= '0;
        inv_r <= '0;
        if (!zpos) res_r.status <= lppb_pkg::ST_BEHIND;
      end
      lppb_pkg::CMD_DIV: begin
        rem_r <= div_ge ? rem_sh - zdiv : rem_sh;
        inv_r <= {inv_r[31:0], div_ge};
      end
      lppb_pkg::CMD_PROJ: begin
        case (cmd.step)
          6'd1: tu_r <= lppb_pkg::sat32(sh);
          6'd2: tv_r <= lppb_pkg::sat32(sh);
          6'd3: u_r  <= sh + 50'($signed(cam_r[lppb_pkg::SEL_CX]));
          6'd4: v_r  <= sh + 50'($signed(cam_r[lppb_pkg::SEL_CY]));
          default: ;
        endcase
      end
      lppb_pkg::CMD_BOUND: begin
        res_r.u_pixel <= lppb_pkg::sat32(u_r);
        res_r.v_pixel <= lppb_pkg::sat32(v_r);
        if (outside) res_r.status <= lppb_pkg::ST_OUT;
        sidx_r <= '0;
        sv_r   <= 1'b0;
      end
      lppb_pkg::CMD_SRCH: begin
        // Read one box a cycle; compare the one read in the cycle before.
        sidx_r <= sidx_r + 7'd1;
        sv_r   <= 9'(sidx_r) < nb9;
        sk_r   <= sidx_r[5:0];
        if (hit) begin
          gb_r             <= gb9[CAW-1:0];
          res_r.global_box <= gb9[5:0];
        end
        if (miss) res_r.status <= lppb_pkg::ST_NOBOX;
      end
      lppb_pkg::CMD_MATCH: begin
        res_r.status      <= lppb_pkg::ST_MATCH;
        res_r.rank_in_box <= cnt_val[11:0];
      end
      lppb_pkg::CMD_QRY: begin
        // Walk the counts from box zero up to the queried box.
        qidx_r <= qidx_r + 1'b1;
        qv_r   <= 1'b1;
        qk_r   <= qidx_r;
        if (qv_r) begin
          if (qdone) begin
            res_r.box_total  <= cnt_val;
            res_r.box_offset <= off_r;
          end else begin
            off_r <= off_r + cnt_val;
          end
        end
      end
      default: ;
    endcase
  end

endmodule

[dv/lidar_point_projection_box_binning_chk.sv]
`timescale 1ns / 1ps

module lidar_point_projection_box_binning_chk
  import lppb_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_stall,
  input  lppb_in_t  in_data,
  input  logic      out_valid,
  input  logic      out_stall,
  input  lppb_out_t out_data,
  output int        errors,
  output int        pending
);

  localparam int NUM_POINTS = 4096;
  localparam int NUM_BOXES  = 64;

  // Shadow copy of the binning state.
  logic               point_taken [NUM_POINTS];
  logic        [31:0] hits_per_box [NUM_BOXES];
  lppb_box_t          box_rects [NUM_BOXES];
  logic signed [31:0] cam_reg [15];
  int unsigned        box_base;
  int unsigned        boxes_loaded;
  logic        [31:0] behind_cnt;
  logic        [31:0] outside_cnt;

  // Expected results, oldest first.
  lppb_out_t result_q[$];

  assign pending = result_q.size();

  initial begin
    errors = 0;
    foreach (point_taken[i]) point_taken[i] = 1'b0;
    foreach (hits_per_box[i]) hits_per_box[i] = '0;
    foreach (box_rects[i]) box_rects[i] = '0;
    foreach (cam_reg[i]) cam_reg[i] = '0;
    box_base = 0;
    boxes_loaded = 0;
    behind_cnt = '0;
    outside_cnt = '0;
  end

  function automatic longint clamp32(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // One row of the rigid transform with lidar z taken as zero.
  function automatic longint cam_row(input int r, input longint x, input longint y);
    longint s;
    s = ((longint'(cam_reg[3*r]) * x) >>> 16) + ((longint'(cam_reg[3*r+1]) * y) >>> 16)
        + longint'(cam_reg[3*r+2]);
    return clamp32(s);
  endfunction

  function automatic longint to_pixel(input longint f, input longint c, input longint inv,
                                      input longint c0);
    longint t;
    t = clamp32((f * c) >>> 16);
    return ((t * inv) >>> 16) + c0;
  endfunction

  // Projection, bounds test and first-match box search for a point beat.
  function automatic logic [2:0] bin_point(input lppb_in_t d, inout lppb_out_t r);
    int unsigned room, nb, gb;
    longint x, y, cx, cy, cz, inv, u, v, ui, vi, wlim, hlim;
    room = (box_base < NUM_BOXES) ? NUM_BOXES - box_base : 0;
    nb = (boxes_loaded < room) ? boxes_loaded : room;
    if (cam_reg[SEL_WIDTH] == 0 || cam_reg[SEL_HEIGHT] == 0 ||
        cam_reg[SEL_FX] == 0 || cam_reg[SEL_FY] == 0) return ST_BADCAM;
    if (nb == 0) return ST_IGN;
    if (point_taken[d.point_index]) return ST_DONE;
    x = longint'($signed(d.point_x));
    y = longint'($signed(d.point_y));
    cx = cam_row(0, x, y);
    cy = cam_row(1, x, y);
    cz = cam_row(2, x, y);
    if (cz <= 0) begin
      behind_cnt++;
      return ST_BEHIND;
    end
    inv = (64'sd1 <<< 32) / cz;
    u = to_pixel(longint'(cam_reg[SEL_FX]), cx, inv, longint'(cam_reg[SEL_CX]));
    v = to_pixel(longint'(cam_reg[SEL_FY]), cy, inv, longint'(cam_reg[SEL_CY]));
    r.u_pixel = 32'(clamp32(u));
    r.v_pixel = 32'(clamp32(v));
    wlim = longint'($unsigned(cam_reg[SEL_WIDTH])) * 65536;
    hlim = longint'($unsigned(cam_reg[SEL_HEIGHT])) * 65536;
    if (u < 0 || v < 0 || u >= wlim || v >= hlim) begin
      outside_cnt++;
      return ST_OUT;
    end
    ui = u >>> 16;
    vi = v >>> 16;
    for (int b = 0; b < nb; b++) begin
      if (ui >= box_rects[b].left && ui < box_rects[b].right &&
          vi >= box_rects[b].top && vi < box_rects[b].bottom) begin
        gb = box_base + b;
        point_taken[d.point_index] = 1'b1;
        r.global_box = gb[5:0];
        r.rank_in_box = hits_per_box[gb][11:0];
        hits_per_box[gb]++;
        return ST_MATCH;
      end
    end
    return ST_NOBOX;
  endfunction

  // Applies one input beat to the shadow state and returns its result.
  function automatic lppb_out_t binning_result(input lppb_in_t d);
    lppb_out_t   r;
    int unsigned room, sum;
    r = '0;
    r.status = ST_ACK;
    case (d.op)
      OP_CLEAR: begin
        foreach (point_taken[i]) point_taken[i] = 1'b0;
        foreach (hits_per_box[i]) hits_per_box[i] = '0;
        box_base = 0;
        boxes_loaded = 0;
        behind_cnt = '0;
        outside_cnt = '0;
      end
      OP_PARAM: begin
        if (d.param_sel == SEL_BAD) r.status = ST_IGN;
        else cam_reg[d.param_sel] = d.param_value;
      end
      OP_LOAD: begin
        room = (box_base < NUM_BOXES) ? NUM_BOXES - box_base : 0;
        if (d.box_slot < room) begin
          box_rects[d.box_slot] = '{d.box_left, d.box_top, d.box_right, d.box_bottom};
          if (d.box_slot + 1 > boxes_loaded) boxes_loaded = d.box_slot + 1;
        end else begin
          r.status = ST_IGN;
        end
      end
      OP_POINT: r.status = bin_point(d, r);
      OP_COMMIT: begin
        box_base = (box_base + boxes_loaded > NUM_BOXES) ? NUM_BOXES
                                                         : box_base + boxes_loaded;
        boxes_loaded = 0;
      end
      OP_QUERY: begin
        sum = 0;
        for (int k = 0; k < d.box_slot; k++) sum += hits_per_box[k];
        r.box_total = hits_per_box[d.box_slot][12:0];
        r.box_offset = sum[12:0];
      end
      default: r.status = ST_IGN;
    endcase
    r.behind_total = behind_cnt;
    r.outside_total = outside_cnt;
    return r;
  endfunction

  task automatic report(input string field, input logic [31:0] got, input logic [31:0] want);
    $display("mismatch %s: got %0h, expected %0h at %0t", field, got, want, $realtime);
    errors++;
  endtask

  // Predict on every accepted input beat and compare every accepted result beat.
  always @(posedge clk) begin
    lppb_out_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (result_q.size() == 0) begin
        report("unexpected beat", out_data.status, '0);
      end else begin
        e = result_q.pop_front();
        if (out_data.status != e.status) report("status", out_data.status, e.status);
        if (out_data.u_pixel != e.u_pixel) report("u_pixel", out_data.u_pixel, e.u_pixel);
        if (out_data.v_pixel != e.v_pixel) report("v_pixel", out_data.v_pixel, e.v_pixel);
        if (out_data.global_box != e.global_box)
          report("global_box", out_data.global_box, e.global_box);
        if (out_data.rank_in_box != e.rank_in_box)
          report("rank_in_box", out_data.rank_in_box, e.rank_in_box);
        if (out_data.box_total != e.box_total)
          report("box_total", out_data.box_total, e.box_total);
        if (out_data.box_offset != e.box_offset)
          report("box_offset", out_data.box_offset, e.box_offset);
        if (out_data.behind_total != e.behind_total)
          report("behind_total", out_data.behind_total, e.behind_total);
        if (out_data.outside_total != e.outside_total)
          report("outside_total", out_data.outside_total, e.outside_total);
      end
    end
    if (rst_n && in_valid && !in_stall) result_q.push_back(binning_result(in_data));
  end

endmodule

[dv/lidar_point_projection_box_binning_tb.sv]
`timescale 1ns / 1ps

module lidar_point_projection_box_binning_tb;
  import lppb_pkg::*;

  localparam int ITEM_GOAL   = 1700;
  localparam int CYCLE_LIMIT = 3000000;
  localparam int DRAIN_WAIT  = 4300;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  lppb_in_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  lppb_out_t out_data;
  int        errors;
  int        pending;
  int        cycles = 0;
  int        beats_sent = 0;
  int        stall_left = 0;
  bit        calm = 1'b0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  lidar_point_projection_box_binning u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  lidar_point_projection_box_binning_chk u_chk (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .errors(errors), .pending(pending)
  );

  // Run guard.
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Result-side back-pressure: a fresh stall length after every accepted beat.
  always @(posedge clk) begin
    if (out_valid && !out_stall) stall_left = calm ? 0 : $urandom_range(0, 18);
  end

  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_stall = 1'b1;
    end else begin
      out_stall = 1'b0;
    end
  end

  // Drives one beat after a random gap (none while calm) and holds it until it is taken.
  task automatic send(input lppb_in_t d);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    in_data = d;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    in_valid = 1'b0;
    beats_sent++;
  endtask

  function automatic lppb_in_t beat(input logic [2:0] op);
    lppb_in_t d;
    d = '0;
    d.op = op;
    return d;
  endfunction

  // Any beat at all; every field is random, over its whole width but the box edges (0 to 8192).
  function automatic lppb_in_t noise_beat();
    lppb_in_t d;
    d.op = $urandom_range(0, 7);
    d.param_sel = $urandom_range(0, 15);
    d.param_value = $urandom;
    d.box_slot = $urandom_range(0, 63);
    d.box_left = $urandom_range(0, 8192);
    d.box_top = $urandom_range(0, 8192);
    d.box_right = $urandom_range(0, 8192);
    d.box_bottom = $urandom_range(0, 8192);
    d.point_index = $urandom_range(0, 4095);
    d.point_x = $urandom;
    d.point_y = $urandom;
    return d;
  endfunction

  task automatic set_param(input logic [3:0] sel, input logic [31:0] val);
    lppb_in_t d;
    d = beat(OP_PARAM);
    d.param_sel = sel;
    d.param_value = val;
    send(d);
  endtask

  task automatic load_box(input int slot, input bit wild);
    lppb_in_t d;
    d = beat(OP_LOAD);
    d.box_slot = slot;
    if (wild) begin
      d.box_left = $urandom_range(0, 8192);
      d.box_top = $urandom_range(0, 8192);
      d.box_right = $urandom_range(0, 8192);
      d.box_bottom = $urandom_range(0, 8192);
    end else begin
      d.box_left = $urandom_range(0, 600);
      d.box_top = $urandom_range(0, 440);
      d.box_right = d.box_left + $urandom_range(0, 200);
      d.box_bottom = d.box_top + $urandom_range(0, 200);
    end
    send(d);
  endtask

  // Camera that maps lidar x, y to pixels, with an optional tilt that makes
  // far points land behind the camera; otherwise a fully random camera.
  task automatic set_camera();
    if ($urandom_range(0, 3) != 0) begin
      set_param(4'd0, 32'd65536);
      set_param(4'd1, 32'd0);
      set_param(4'd2, 32'd0);
      set_param(4'd3, 32'd0);
      set_param(4'd4, 32'd65536);
      set_param(4'd5, 32'd0);
      set_param(4'd6, $urandom_range(0, 1) ? -32'sd64 : 32'sd0);
      set_param(4'd7, 32'd0);
      set_param(4'd8, 32'd65536);
      set_param(SEL_FX, ($urandom_range(0, 9) == 0) ? 32'd0 : 32'd65536);
      set_param(SEL_FY, 32'd65536);
      set_param(SEL_CX, 32'd0);
      set_param(SEL_CY, 32'd0);
      set_param(SEL_WIDTH, 32'd640);
      set_param(SEL_HEIGHT, 32'd480);
    end else begin
      for (int k = 0; k < 13; k++) set_param(k, $urandom);
      set_param(SEL_WIDTH, $urandom_range(0, 1) ? $urandom : $urandom_range(1, 8192));
      set_param(SEL_HEIGHT, $urandom_range(0, 1) ? $urandom : $urandom_range(1, 8192));
    end
  endtask

  task automatic send_point();
    lppb_in_t d;
    d = beat(OP_POINT);
    d.point_index = ($urandom_range(0, 3) != 0) ? $urandom_range(0, 95)
                                                 : $urandom_range(0, 4095);
    if ($urandom_range(0, 7) == 0) begin
      d.point_x = $urandom;
      d.point_y = $urandom;
    end else begin
      d.point_x = ($urandom_range(0, 1200) - 60) * 65536 + $urandom_range(0, 65535);
      d.point_y = ($urandom_range(0, 600) - 60) * 65536 + $urandom_range(0, 65535);
    end
    send(d);
  endtask

  task automatic send_query();
    lppb_in_t d;
    d = beat(OP_QUERY);
    d.box_slot = $urandom_range(0, 63);
    send(d);
  endtask

  initial begin
    lppb_in_t d;
    int       phase;
    int       nbox;
    repeat (5) @(negedge clk);
    rst_n = 1'b1;

    // Directed opening: a point before any camera exists, then every slot of the
    // box store written, which also fills the whole box range in one call.
    calm = 1'b1;
    send(beat(OP_POINT));
    for (int s = 0; s < 64; s++) load_box(s, s[0]);
    send(beat(OP_COMMIT));
    d = beat(OP_LOAD);
    send(d);
    send(beat(OP_POINT));
    d = beat(OP_QUERY);
    d.box_slot = 6'd63;
    send(d);
    set_param(SEL_BAD, 32'h7fffffff);
    set_param(4'd0, 32'h80000000);
    send(beat(3'd6));
    send(beat(3'd7));
    send(beat(OP_CLEAR));
    calm = 1'b0;

    // Random calls: camera, boxes, a burst of points, queries and, most times, a commit.
    phase = 0;
    while (beats_sent < ITEM_GOAL) begin
      calm = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 4) == 0) send(beat(OP_CLEAR));
      if (phase == 0 || $urandom_range(0, 2) == 0) set_camera();
      nbox = $urandom_range(1, 8);
      for (int s = 0; s < nbox; s++) load_box(s, $urandom_range(0, 7) == 0);
      repeat ($urandom_range(15, 40)) begin
        if ($urandom_range(0, 9) == 0) send(noise_beat());
        else if ($urandom_range(0, 9) == 0) send_query();
        else send_point();
      end
      repeat ($urandom_range(1, 4)) send_query();
      if ($urandom_range(0, 5) != 0) send(beat(OP_COMMIT));
      if (phase == 5) begin
        while (pending != 0) @(negedge clk);
      end
      phase++;
    end

    // Drain.
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_WAIT) @(negedge clk);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

[lidar_point_projection_box_binning.f]
design/lppb_pkg.sv
design/lppb_ram.sv
design/lppb_ctrl.sv
design/lppb_dp.sv
design/lidar_point_projection_box_binning.sv
dv/lidar_point_projection_box_binning_chk.sv
dv/lidar_point_projection_box_binning_tb.sv
